[sv/prt_pkg.sv]
// shared types, constants and command/status structs of the page transfer receiver
`default_nettype none

package prt_pkg;

  localparam int WORDS_PER_PAGE = 64;
  localparam int IDX_W          = $clog2(WORDS_PER_PAGE);
  localparam int WORD_W         = 32;
  localparam int PAGE_BYTES     = WORDS_PER_PAGE * 4;
  localparam int BYTE_CNT_W     = $clog2(PAGE_BYTES);

  localparam logic [WORD_W-1:0] IMAGE_BYTES = 32'd1048576;
  localparam logic [WORD_W-1:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [WORD_W-1:0] CRC_INIT    = 32'hFFFFFFFF;

  localparam int IN_TDATA_W  = 96;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 3;

  typedef enum logic [1:0] {
    OP_BEGIN,
    OP_DATA,
    OP_END,
    OP_CANCEL
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IGNORED,
    ST_PROGRESS,
    ST_INVALID,
    ST_COMPLETE,
    ST_BEGUN,
    ST_REJECTED,
    ST_CANCELLED
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_CRC,
    S_CHECK,
    S_EMIT
  } fsm_state_t;

  typedef enum logic [2:0] {
    RD_INPUT,
    RD_ITEM,
    RD_ZERO,
    RD_CRC,
    RD_EMIT
  } rd_sel_t;

  typedef struct packed {
    logic    take_in;
    logic    commit;
    logic    crc_start;
    logic    crc_step;
    logic    finish_ok;
    logic    load_result;
    logic    load_invalid;
    logic    emit_start;
    logic    load_word;
    rd_sel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    logic go_crc;
    logic out_free;
    logic crc_done;
    logic crc_match;
    logic emit_last;
  } sts_t;

endpackage

`default_nettype wire

[sv/prt_datapath.sv]
// datapath: item register, page state, page memory, crc unit and result register
`default_nettype none

module prt_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [prt_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  wire logic [prt_pkg::IN_TUSER_W-1:0]       in_tuser,
  input  wire prt_pkg::cmd_t                        cmd,
  output prt_pkg::sts_t                             sts,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [prt_pkg::OUT_TDATA_W-1:0]           out_tdata,
  output logic [prt_pkg::OUT_TUSER_W-1:0]           out_tuser,
  output logic                                      out_tlast
);

  typedef struct packed {
    prt_pkg::status_t status;
    logic             begin_page;
    logic             clear;
    logic             fail;
    logic             store;
    logic             mark_end;
    logic             go_crc;
  } eval_t;

  function automatic logic [prt_pkg::WORD_W-1:0] crc_byte(
    input logic [prt_pkg::WORD_W-1:0] crc_in,
    input logic [7:0]                 data
  );
    logic [prt_pkg::WORD_W-1:0] c;
    c = crc_in ^ {{(prt_pkg::WORD_W-8){1'b0}}, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (prt_pkg::CRC_POLY & {prt_pkg::WORD_W{c[0]}});
    end
    return c;
  endfunction

  // item register
  prt_pkg::opcode_t            ir_op_r;
  logic [prt_pkg::WORD_W-1:0]  ir_id_r;
  logic [prt_pkg::WORD_W-1:0]  ir_payload_r;
  logic [prt_pkg::WORD_W-1:0]  ir_addr_r;

  // page state
  logic                              active_r;
  logic [prt_pkg::WORD_W-1:0]        tag_r;
  logic [prt_pkg::WORDS_PER_PAGE-1:0] map_r;
  logic                              end_seen_r;
  logic [prt_pkg::WORD_W-1:0]        exp_crc_r;

  // page memory
  logic [prt_pkg::WORD_W-1:0] mem [prt_pkg::WORDS_PER_PAGE];
  logic [prt_pkg::WORD_W-1:0] rd_data_r;
  logic [prt_pkg::IDX_W-1:0]  raddr;
  logic                       we;

  // crc and emit counters
  logic [prt_pkg::WORD_W-1:0]     crc_r;
  logic [prt_pkg::BYTE_CNT_W-1:0] byte_cnt_r;
  logic [prt_pkg::BYTE_CNT_W-1:0] byte_cnt_inc;
  logic [prt_pkg::IDX_W-1:0]      e_cnt_r;
  logic [prt_pkg::IDX_W-1:0]      e_cnt_inc;
  logic [7:0]                     crc_in_byte;

  // result register
  logic                        out_valid_r;
  prt_pkg::status_t            out_status_r;
  logic [prt_pkg::IDX_W-1:0]   out_index_r;
  logic [prt_pkg::WORD_W-1:0]  out_data_r;
  logic                        out_last_r;

  eval_t                              ev;
  logic [prt_pkg::IDX_W-1:0]          idx;
  logic [prt_pkg::WORDS_PER_PAGE-1:0] bit_sel;
  logic                               tag_ok;
  logic                               addr_ok;
  logic                               out_free;

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      ir_op_r      <= prt_pkg::opcode_t'(in_tuser);
      ir_id_r      <= in_tdata[prt_pkg::WORD_W-1:0];
      ir_payload_r <= in_tdata[2*prt_pkg::WORD_W-1:prt_pkg::WORD_W];
      ir_addr_r    <= in_tdata[3*prt_pkg::WORD_W-1:2*prt_pkg::WORD_W];
    end
  end

  assign idx     = ir_id_r[prt_pkg::IDX_W-1:0];
  assign tag_ok  = (ir_id_r != '0) && (ir_id_r[prt_pkg::IDX_W-1:0] == '0);
  assign addr_ok = (ir_addr_r < prt_pkg::IMAGE_BYTES)
                   && (ir_addr_r[prt_pkg::BYTE_CNT_W-1:0] == '0);

  always_comb begin
    bit_sel      = '0;
    bit_sel[idx] = 1'b1;
  end

  always_comb begin
    ev        = '0;
    ev.status = prt_pkg::ST_IGNORED;
    unique case (ir_op_r)
      prt_pkg::OP_BEGIN: begin
        if (tag_ok && addr_ok) begin
          ev.status     = prt_pkg::ST_BEGUN;
          ev.begin_page = 1'b1;
        end else begin
          ev.status = prt_pkg::ST_REJECTED;
        end
      end
      prt_pkg::OP_CANCEL: begin
        ev.status = prt_pkg::ST_CANCELLED;
        ev.clear  = 1'b1;
      end
      prt_pkg::OP_DATA: begin
        if (active_r
            && ({ir_id_r[prt_pkg::WORD_W-1:prt_pkg::IDX_W], {prt_pkg::IDX_W{1'b0}}} == tag_r))
        begin
          if (map_r[idx]) begin
            if (rd_data_r != ir_payload_r) begin
              ev.status = prt_pkg::ST_INVALID;
              ev.fail   = 1'b1;
            end
          end else begin
            ev.store = 1'b1;
            if ((&(map_r | bit_sel)) && end_seen_r) begin
              ev.go_crc = 1'b1;
            end else begin
              ev.status = prt_pkg::ST_PROGRESS;
            end
          end
        end
      end
      prt_pkg::OP_END: begin
        if (active_r && (ir_id_r == tag_r)) begin
          if (end_seen_r) begin
            if (exp_crc_r != ir_payload_r) begin
              ev.status = prt_pkg::ST_INVALID;
              ev.fail   = 1'b1;
            end
          end else begin
            ev.mark_end = 1'b1;
            if (&map_r) begin
              ev.go_crc = 1'b1;
            end else begin
              ev.status = prt_pkg::ST_PROGRESS;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      tag_r      <= '0;
      map_r      <= '0;
      end_seen_r <= 1'b0;
      exp_crc_r  <= '0;
    end else begin
      if (cmd.commit) begin
        if (ev.begin_page) begin
          active_r   <= 1'b1;
          tag_r      <= ir_id_r;
          map_r      <= '0;
          end_seen_r <= 1'b0;
          exp_crc_r  <= '0;
        end else if (ev.clear) begin
          active_r   <= 1'b0;
          tag_r      <= '0;
          map_r      <= '0;
          end_seen_r <= 1'b0;
          exp_crc_r  <= '0;
        end else if (ev.fail) begin
          active_r <= 1'b0;
        end else if (ev.store) begin
          map_r <= map_r | bit_sel;
        end else if (ev.mark_end) begin
          end_seen_r <= 1'b1;
          exp_crc_r  <= ir_payload_r;
        end
      end
      if (cmd.finish_ok || cmd.load_invalid) begin
        active_r <= 1'b0;
      end
    end
  end

  assign we           = cmd.commit && ev.store;
  assign byte_cnt_inc = byte_cnt_r + 1'b1;
  assign e_cnt_inc    = e_cnt_r + 1'b1;

  // read address runs one step ahead so the registered word lines up
  always_comb begin
    unique case (cmd.rd_sel)
      prt_pkg::RD_INPUT: raddr = in_tdata[prt_pkg::IDX_W-1:0];
      prt_pkg::RD_ITEM:  raddr = idx;
      prt_pkg::RD_ZERO:  raddr = '0;
      prt_pkg::RD_CRC:   raddr = byte_cnt_inc[prt_pkg::BYTE_CNT_W-1:2];
      prt_pkg::RD_EMIT:  raddr = cmd.load_word ? e_cnt_inc : e_cnt_r;
      default:           raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx] <= ir_payload_r;
    end
    if (we && (idx == raddr)) begin
      rd_data_r <= ir_payload_r;
    end else begin
      rd_data_r <= mem[raddr];
    end
  end

  assign crc_in_byte = rd_data_r[{byte_cnt_r[1:0], 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
      e_cnt_r    <= '0;
    end else begin
      if (cmd.crc_start) begin
        byte_cnt_r <= '0;
      end else if (cmd.crc_step) begin
        byte_cnt_r <= byte_cnt_inc;
      end
      if (cmd.emit_start) begin
        e_cnt_r <= '0;
      end else if (cmd.load_word) begin
        e_cnt_r <= e_cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.crc_start) begin
      crc_r <= prt_pkg::CRC_INIT;
    end else if (cmd.crc_step) begin
      crc_r <= crc_byte(crc_r, crc_in_byte);
    end
  end

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_result || cmd.load_invalid || cmd.load_word) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_status_r <= ev.status;
      out_index_r  <= '0;
      out_data_r   <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.load_invalid) begin
      out_status_r <= prt_pkg::ST_INVALID;
      out_index_r  <= '0;
      out_data_r   <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.load_word) begin
      out_status_r <= prt_pkg::ST_COMPLETE;
      out_index_r  <= e_cnt_r;
      out_data_r   <= rd_data_r;
      out_last_r   <= sts.emit_last;
    end
  end

  assign sts.go_crc    = ev.go_crc;
  assign sts.out_free  = out_free;
  assign sts.crc_done  = (byte_cnt_r == {prt_pkg::BYTE_CNT_W{1'b1}});
  assign sts.crc_match = ((~crc_r) == exp_crc_r);
  assign sts.emit_last = (e_cnt_r == {prt_pkg::IDX_W{1'b1}});

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(prt_pkg::OUT_TDATA_W-prt_pkg::WORD_W-prt_pkg::IDX_W){1'b0}},
                       out_data_r, out_index_r};

endmodule

`default_nettype wire

[sv/prt_ctrl.sv]
// controller state machine: sequences evaluation, crc walk and page emission
`default_nettype none

module prt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire prt_pkg::sts_t sts,
  output prt_pkg::cmd_t      cmd
);

  prt_pkg::fsm_state_t state_r;
  prt_pkg::fsm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      prt_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = prt_pkg::S_EVAL;
      end
      prt_pkg::S_EVAL: begin
        priority if (sts.go_crc) state_nxt = prt_pkg::S_CRC;
        else if (sts.out_free)   state_nxt = prt_pkg::S_IDLE;
        else                     state_nxt = prt_pkg::S_EVAL;
      end
      prt_pkg::S_CRC: begin
        if (sts.crc_done) state_nxt = prt_pkg::S_CHECK;
      end
      prt_pkg::S_CHECK: begin
        priority if (sts.crc_match) state_nxt = prt_pkg::S_EMIT;
        else if (sts.out_free)      state_nxt = prt_pkg::S_IDLE;
        else                        state_nxt = prt_pkg::S_CHECK;
      end
      prt_pkg::S_EMIT: begin
        if (sts.out_free && sts.emit_last) state_nxt = prt_pkg::S_IDLE;
      end
      default: state_nxt = prt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = prt_pkg::RD_ZERO;
    in_tready  = 1'b0;
    unique case (state_r)
      prt_pkg::S_IDLE: begin
        in_tready   = 1'b1;
        cmd.take_in = in_tvalid;
        cmd.rd_sel  = prt_pkg::RD_INPUT;
      end
      prt_pkg::S_EVAL: begin
        if (sts.go_crc) begin
          cmd.commit    = 1'b1;
          cmd.crc_start = 1'b1;
          cmd.rd_sel    = prt_pkg::RD_ZERO;
        end else begin
          cmd.rd_sel = prt_pkg::RD_ITEM;
          if (sts.out_free) begin
            cmd.commit      = 1'b1;
            cmd.load_result = 1'b1;
          end
        end
      end
      prt_pkg::S_CRC: begin
        cmd.crc_step = 1'b1;
        cmd.rd_sel   = prt_pkg::RD_CRC;
      end
      prt_pkg::S_CHECK: begin
        if (sts.crc_match) begin
          cmd.finish_ok  = 1'b1;
          cmd.emit_start = 1'b1;
        end else if (sts.out_free) begin
          cmd.load_invalid = 1'b1;
        end
      end
      prt_pkg::S_EMIT: begin
        cmd.rd_sel    = prt_pkg::RD_EMIT;
        cmd.load_word = sts.out_free;
      end
      default: begin
        cmd.rd_sel = prt_pkg::RD_ZERO;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/page_transfer_receiver.sv]
// top level of the page transfer receiver: controller plus datapath
//
// in channel: one frame per transfer; in_tuser carries the opcode (begin,
// data, end, cancel), in_tdata carries id_word, payload and page_address.
// out channel: one result per transfer; out_tuser carries the status,
// out_tdata the word index and word data, out_tlast marks the final result
// caused by one frame.
// an ordinary frame is accepted in S_IDLE, then evaluated against the page
// state and the registered page-memory read in S_EVAL, after which in_tready
// rises again; its single result is loaded once the output register is free.
// the frame that completes the page walks the page memory one byte a cycle
// through the crc unit, compares the crc in S_CHECK, then emits 64 complete
// results, one per cycle while out_tready is high, and holds in_tready low
// until the last of them is loaded.
// a finished result waits in the output register while the next frame is
// accepted; a stalled receiver holds the block in evaluation, check or emission.
// reset clears the page state and the output valid flag; page memory contents
// are not cleared and are only used at words already received.
`default_nettype none

module page_transfer_receiver (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [31:0] id_word, [63:32] payload, [95:64] page_address
  input  wire logic [prt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] opcode
  input  wire logic [prt_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [5:0] word_index, [37:6] word_data, [39:38] zero
  output logic [prt_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // [2:0] status
  output logic [prt_pkg::OUT_TUSER_W-1:0]      out_tuser,
  output logic                                 out_tlast
);

  prt_pkg::cmd_t cmd;
  prt_pkg::sts_t sts;

  prt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  prt_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[sv/prt_checker.sv]
// port-level checker of the page transfer receiver and its bind
`default_nettype none

module prt_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [prt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [prt_pkg::OUT_TUSER_W-1:0] out_tuser,
  input wire logic                            out_tlast
);

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // single results are last and carry no word
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != prt_pkg::ST_COMPLETE) |-> out_tlast && (out_tdata == '0))
    else $error("single result malformed");

  // no frame taken while a page is being emitted
  a_emit_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == prt_pkg::ST_COMPLETE) && !out_tlast |-> !in_tready)
    else $error("frame accepted during page emission");

  // final emitted word is the top index
  a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == prt_pkg::ST_COMPLETE) && out_tlast
      |-> (out_tdata[prt_pkg::IDX_W-1:0] == {prt_pkg::IDX_W{1'b1}}))
    else $error("last page word has wrong index");

  // reset empties the result channel
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind page_transfer_receiver prt_checker u_prt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
